// File: src/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the spectral Poisson scaler.
// ----------------------------------------------------------------------------
package sps_pkg;

    // Default largest grid size along one axis.
    localparam int SPS_MAX_SIZE = 1024;

    // Field widths.
    localparam int IDX_W   = 10;
    localparam int SIZE_W  = 11;
    localparam int SCALE_W = 32;
    localparam int COEF_W  = 32;
    localparam int SQ_W    = 2 * SIZE_W - 1;   // square of a magnitude up to 1024
    localparam int TERM_W  = SQ_W + SCALE_W;   // one axis term
    localparam int DIV_W   = TERM_W + 1;       // sum of three terms
    localparam int QUO_W   = 33;               // quotient bits kept
    localparam int REM_W   = DIV_W + QUO_W;    // partial remainder
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DIMS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z = 3'd5;

    // Dimension codes.
    localparam logic [1:0] DIMS_ONE   = 2'd1;
    localparam logic [1:0] DIMS_TWO   = 2'd2;
    localparam logic [1:0] DIMS_THREE = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]         idx_x;
        logic [IDX_W-1:0]         idx_y;
        logic [IDX_W-1:0]         idx_z;
        logic signed [COEF_W-1:0] coef_re;
        logic signed [COEF_W-1:0] coef_im;
    } sps_in_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] out_re;
        logic signed [COEF_W-1:0] out_im;
        logic                     saturated;
    } sps_out_t;

endpackage

// File: src/spectral_poisson_scaler.sv
// ----------------------------------------------------------------------------
// spectral_poisson_scaler
// Divides a complex spectrum coefficient by minus its squared wave number.
// ----------------------------------------------------------------------------
// Pipeline: 5 front stages, 33 restoring-division stages and one output stage
// lie between an accepted request and its result.
// Throughput: one request per cycle while the output is not stalled; the divider
// pipeline resolves one quotient bit per stage. A stall at the output freezes the whole pipe.
// Reset: aresetn synchronous, active low; clears valid bits and restores
// the configuration registers to their defaults.
module spectral_poisson_scaler
    import sps_pkg::*;
#(
    parameter int MAX_SIZE = SPS_MAX_SIZE
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sps_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sps_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int NST = QUO_W;

    // Configuration registers.
    logic [1:0]         dims_reg;
    logic [SIZE_W-1:0]  size_x_reg, size_y_reg;
    logic [SCALE_W-1:0] scale_x_reg, scale_y_reg, scale_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg    <= DIMS_THREE;
            size_x_reg  <= SIZE_W'(256);
            size_y_reg  <= SIZE_W'(256);
            scale_x_reg <= 32'h0100_0000;
            scale_y_reg <= 32'h0100_0000;
            scale_z_reg <= 32'h0100_0000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DIMS:    dims_reg    <= cfg_data[1:0];
                REG_SIZE_X:  size_x_reg  <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:  size_y_reg  <= cfg_data[SIZE_W-1:0];
                REG_SCALE_X: scale_x_reg <= cfg_data;
                REG_SCALE_Y: scale_y_reg <= cfg_data;
                REG_SCALE_Z: scale_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipe advances when the output register is free or being taken.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Effective dims and clamped sizes.
    logic use_y, use_z, wrap_x, wrap_y;
    logic [SIZE_W-1:0] sx_eff, sy_eff;
    assign use_z  = (dims_reg == DIMS_THREE);
    assign use_y  = (dims_reg == DIMS_TWO) || use_z;
    assign wrap_x = use_y;
    assign wrap_y = use_z;
    assign sx_eff = (32'(size_x_reg) > MAX_SIZE) ? SIZE_W'(MAX_SIZE) : size_x_reg;
    assign sy_eff = (32'(size_y_reg) > MAX_SIZE) ? SIZE_W'(MAX_SIZE) : size_y_reg;

    function automatic logic [SIZE_W-1:0] wrap_mag(input logic [IDX_W-1:0] f,
                                                   input logic [SIZE_W-1:0] sz,
                                                   input logic wrap);
        logic [SIZE_W-1:0] fe;
        fe = SIZE_W'(f);
        if (wrap && fe > (sz >> 1)) begin
            wrap_mag = (fe >= sz) ? fe - sz : sz - fe;
        end else begin
            wrap_mag = fe;
        end
    endfunction

    // Stage 1: axis magnitudes after wrap, DC detection.
    logic                     v1_reg, dc1_reg;
    logic [SIZE_W-1:0]        mx1_reg, my1_reg, mz1_reg;
    logic signed [COEF_W-1:0] re1_reg, im1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mx1_reg <= wrap_mag(s_data.idx_x, sx_eff, wrap_x);
            my1_reg <= use_y ? wrap_mag(s_data.idx_y, sy_eff, wrap_y) : '0;
            mz1_reg <= use_z ? SIZE_W'(s_data.idx_z) : '0;
            dc1_reg <= (s_data.idx_x == '0) && (!use_y || s_data.idx_y == '0) &&
                       (!use_z || s_data.idx_z == '0);
            re1_reg <= s_data.coef_re;
            im1_reg <= s_data.coef_im;
        end
    end

    // Stage 2: squares.
    logic                     v2_reg, dc2_reg;
    logic [SQ_W-1:0]          qx2_reg, qy2_reg, qz2_reg;
    logic signed [COEF_W-1:0] re2_reg, im2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            qx2_reg <= SQ_W'(mx1_reg) * SQ_W'(mx1_reg);
            qy2_reg <= SQ_W'(my1_reg) * SQ_W'(my1_reg);
            qz2_reg <= SQ_W'(mz1_reg) * SQ_W'(mz1_reg);
            dc2_reg <= dc1_reg;
            re2_reg <= re1_reg;
            im2_reg <= im1_reg;
        end
    end

    // Stage 3: axis terms, square times scale.
    logic                     v3_reg, dc3_reg;
    logic [TERM_W-1:0]        tx3_reg, ty3_reg, tz3_reg;
    logic signed [COEF_W-1:0] re3_reg, im3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tx3_reg <= TERM_W'(qx2_reg) * TERM_W'(scale_x_reg);
            ty3_reg <= TERM_W'(qy2_reg) * TERM_W'(scale_y_reg);
            tz3_reg <= TERM_W'(qz2_reg) * TERM_W'(scale_z_reg);
            dc3_reg <= dc2_reg;
            re3_reg <= re2_reg;
            im3_reg <= im2_reg;
        end
    end

    // Stage 4: divisor sum and coefficient magnitudes.
    logic              v4_reg, dc4_reg, nre4_reg, nim4_reg;
    logic [DIV_W-1:0]  d4_reg;
    logic [COEF_W:0]   are4_reg, aim4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d4_reg   <= DIV_W'(tx3_reg) + DIV_W'(ty3_reg) + DIV_W'(tz3_reg);
            dc4_reg  <= dc3_reg;
            nre4_reg <= re3_reg[COEF_W-1];
            nim4_reg <= im3_reg[COEF_W-1];
            are4_reg <= re3_reg[COEF_W-1] ? -(COEF_W+1)'(re3_reg) : (COEF_W+1)'(re3_reg);
            aim4_reg <= im3_reg[COEF_W-1] ? -(COEF_W+1)'(im3_reg) : (COEF_W+1)'(im3_reg);
        end
    end

    // Divider pipeline arrays; entry 0 is the stage 5 result.
    logic             dv_reg  [0:NST];
    logic             dz_reg  [0:NST];
    logic [DIV_W-1:0] dd_reg  [0:NST];
    logic [REM_W-1:0] rre_reg [0:NST];
    logic [REM_W-1:0] rim_reg [0:NST];
    logic [QUO_W-1:0] qre_reg [0:NST];
    logic [QUO_W-1:0] qim_reg [0:NST];
    logic             ore_reg [0:NST];
    logic             oim_reg [0:NST];
    logic             nre_reg [0:NST];
    logic             nim_reg [0:NST];

    // Stage 5: rounded numerator and overflow check against d << 33.
    logic [REM_W-1:0] nume_re, nume_im, dtop;
    assign nume_re = (REM_W'(are4_reg) << 24) + REM_W'(d4_reg >> 1);
    assign nume_im = (REM_W'(aim4_reg) << 24) + REM_W'(d4_reg >> 1);
    assign dtop    = REM_W'(d4_reg) << QUO_W;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dz_reg[0]  <= dc4_reg || (d4_reg == '0);
            dd_reg[0]  <= d4_reg;
            rre_reg[0] <= nume_re;
            rim_reg[0] <= nume_im;
            ore_reg[0] <= (nume_re >= dtop);
            oim_reg[0] <= (nume_im >= dtop);
            qre_reg[0] <= '0;
            qim_reg[0] <= '0;
            nre_reg[0] <= nre4_reg;
            nim_reg[0] <= nim4_reg;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar k = 1; k <= NST; k++) begin : g_div
        localparam int BIT = NST - k;
        logic [REM_W-1:0] sub;
        logic             take_re, take_im;
        assign sub     = REM_W'(dd_reg[k-1]) << BIT;
        assign take_re = !ore_reg[k-1] && (rre_reg[k-1] >= sub);
        assign take_im = !oim_reg[k-1] && (rim_reg[k-1] >= sub);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k] <= 1'b0;
            end else if (adv) begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dz_reg[k]  <= dz_reg[k-1];
                dd_reg[k]  <= dd_reg[k-1];
                rre_reg[k] <= take_re ? rre_reg[k-1] - sub : rre_reg[k-1];
                rim_reg[k] <= take_im ? rim_reg[k-1] - sub : rim_reg[k-1];
                qre_reg[k] <= qre_reg[k-1] | (QUO_W'(take_re) << BIT);
                qim_reg[k] <= qim_reg[k-1] | (QUO_W'(take_im) << BIT);
                ore_reg[k] <= ore_reg[k-1];
                oim_reg[k] <= oim_reg[k-1];
                nre_reg[k] <= nre_reg[k-1];
                nim_reg[k] <= nim_reg[k-1];
            end
        end
    end

    // Negate and saturate one part; a negative coefficient gives a positive result.
    function automatic logic [COEF_W:0] finish(input logic [QUO_W-1:0] q,
                                              input logic ovf,
                                              input logic neg);
        logic [COEF_W-1:0] val;
        logic              sat;
        if (neg) begin
            sat = ovf || (q > QUO_W'(32'h7FFF_FFFF));
            val = sat ? 32'h7FFF_FFFF : q[COEF_W-1:0];
        end else begin
            sat = ovf || (q > QUO_W'(32'h8000_0000));
            val = sat ? 32'h8000_0000 : -q[COEF_W-1:0];
        end
        finish = {sat, val};
    endfunction

    logic [COEF_W:0] fin_re, fin_im;
    assign fin_re = finish(qre_reg[NST], ore_reg[NST], nre_reg[NST]);
    assign fin_im = finish(qim_reg[NST], oim_reg[NST], nim_reg[NST]);

    // Output register.
    logic     m_valid_reg;
    sps_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_reg[NST];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (dz_reg[NST]) begin
                m_data_reg <= '0;
            end else begin
                m_data_reg.out_re    <= fin_re[COEF_W-1:0];
                m_data_reg.out_im    <= fin_im[COEF_W-1:0];
                m_data_reg.saturated <= fin_re[COEF_W] | fin_im[COEF_W];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A saturated result always carries a clipped value in one of its parts.
    a_sat_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.saturated) |->
        (m_data.out_re == 32'sh7FFF_FFFF || m_data.out_re == -32'sh8000_0000 ||
         m_data.out_im == 32'sh7FFF_FFFF || m_data.out_im == -32'sh8000_0000))
        else $error("saturated flag without a clipped part");

    // Without overflow the numerator fits below d << 33 at the divider input.
    a_div_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_reg[0] && !dz_reg[0] && !ore_reg[0]) |->
        (rre_reg[0] < (REM_W'(dd_reg[0]) << QUO_W)))
        else $error("divider input remainder out of range");

    // The final remainder is below the divisor for an exact quotient.
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_reg[NST] && !dz_reg[NST] && !ore_reg[NST]) |->
        (rre_reg[NST] < REM_W'(dd_reg[NST])))
        else $error("divider remainder not reduced");

    // A held output keeps its item while the pipe is frozen.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("output changed while stalled");

endmodule
